/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the keypad decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");
`else
`define AST_IMPL(lbl, clk, rst_n, ante, cons)
`define AST_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/aldb_pkg.sv */
// ----------------------------------------------------------------------------
// aldb_pkg
// Types and constants of the resistor-ladder keypad decoder.
// ----------------------------------------------------------------------------
package aldb_pkg;

    localparam int TABLE_ENTRIES = 6;
    localparam int NUM_SLOTS     = 6;
    localparam int USED_SLOTS    = (TABLE_ENTRIES < NUM_SLOTS) ? TABLE_ENTRIES : NUM_SLOTS;
    localparam int IDX_W         = (USED_SLOTS > 1) ? $clog2(USED_SLOTS) : 1;
    localparam int CNT_W         = 3;
    localparam int ID_W          = 8;
    localparam int TBL_W         = 48;
    localparam int DATA_W        = 64;
    localparam int ADDR_W        = 6;
    localparam int ADDR_LSB      = 3;

    localparam logic [ID_W-1:0] NO_CANDIDATE  = 8'hff;
    localparam logic [7:0]      RST_DELTA     = 8'd10;
    localparam logic [15:0]     RST_TICK      = 16'd20;
    localparam logic [15:0]     RST_DEBOUNCE  = 16'd30;
    localparam logic            RST_DEB_EN    = 1'b1;
    localparam logic [15:0]     RST_HOLD      = 16'd1000;

    typedef enum logic [2:0] {
        REG_BUTTON_IDS,
        REG_BUTTON_LEVELS,
        REG_BUTTON_COUNT,
        REG_MATCH_DELTA,
        REG_TICK_INTERVAL,
        REG_DEBOUNCE_DELAY,
        REG_DEBOUNCE_ENABLE,
        REG_HOLD_DELAY
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DECIDE
    } t_state;

    typedef struct packed {
        logic [31:0] now_ms;
        logic [9:0]  adc_sample;
        logic        report_held;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0] pressed_id;
        logic            press_event;
        logic            hold_event;
        logic            release_event;
        logic [ID_W-1:0] released_id;
        logic [ID_W-1:0] holding_id;
    } t_out_item;

    typedef struct packed {
        logic [TBL_W-1:0] button_ids;
        logic [TBL_W-1:0] button_levels;
        logic [CNT_W-1:0] button_count;
        logic [7:0]       match_delta;
        logic [15:0]      tick_interval_ms;
        logic [15:0]      settle_ms;
        logic             debounce_enable;
        logic [15:0]      repeat_ms;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic check;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic skip;
        logic empty;
        logic hit;
        logic last;
        logic out_free;
    } t_stat;

endpackage

/* hdl/analog_ladder_button_decoder_top.sv */
// ----------------------------------------------------------------------------
// analog_ladder_button_decoder_top
// Resistor-ladder keypad decoder: tick filter, level table search, debounce,
// and press, release and hold-repeat events.
//
//   channel  direction  handshake                  word
//   in       input      i_in_valid / o_in_stall    t_in_item
//   out      output     o_out_valid / i_out_stall  t_out_item
//   config   input      APB psel/penable/pwrite    64-bit registers at 8*i
//
// A word skips the table scan when the sample is too early or the table is empty;
// else the table entries are scanned one per cycle, stopping at the first match.
// The output register lets the next word be accepted while a result waits.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output holds the sequencer in its decision state until it drains.
// ----------------------------------------------------------------------------
module analog_ladder_button_decoder_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  aldb_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output aldb_pkg::t_out_item         o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [aldb_pkg::ADDR_W-1:0] paddr,
    input  logic [aldb_pkg::DATA_W-1:0] pwdata,
    output logic [aldb_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    aldb_pkg::t_cfg  w_cfg;
    aldb_pkg::t_cmd  w_cmd;
    aldb_pkg::t_stat w_stat;

    aldb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    aldb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    aldb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* hdl/aldb_regs.sv */
// ----------------------------------------------------------------------------
// aldb_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module aldb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aldb_pkg::ADDR_W-1:0]   paddr,
    input  logic [aldb_pkg::DATA_W-1:0]   pwdata,
    output logic [aldb_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output aldb_pkg::t_cfg                o_cfg
);

    aldb_pkg::t_cfg   r_cfg;
    aldb_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = aldb_pkg::t_reg_idx'(paddr[aldb_pkg::ADDR_W-1:aldb_pkg::ADDR_LSB]);
    assign w_wr   = psel & penable & pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_ids        <= '0;
            r_cfg.button_levels     <= '0;
            r_cfg.button_count      <= '0;
            r_cfg.match_delta       <= aldb_pkg::RST_DELTA;
            r_cfg.tick_interval_ms  <= aldb_pkg::RST_TICK;
            r_cfg.settle_ms         <= aldb_pkg::RST_DEBOUNCE;
            r_cfg.debounce_enable   <= aldb_pkg::RST_DEB_EN;
            r_cfg.repeat_ms         <= aldb_pkg::RST_HOLD;
        end else if (w_wr) begin
            case (w_idx)
                aldb_pkg::REG_BUTTON_IDS:      r_cfg.button_ids <= pwdata[aldb_pkg::TBL_W-1:0];
                aldb_pkg::REG_BUTTON_LEVELS:   r_cfg.button_levels <= pwdata[aldb_pkg::TBL_W-1:0];
                aldb_pkg::REG_BUTTON_COUNT:    r_cfg.button_count <= pwdata[aldb_pkg::CNT_W-1:0];
                aldb_pkg::REG_MATCH_DELTA:     r_cfg.match_delta <= pwdata[7:0];
                aldb_pkg::REG_TICK_INTERVAL:   r_cfg.tick_interval_ms <= pwdata[15:0];
                aldb_pkg::REG_DEBOUNCE_DELAY:  r_cfg.settle_ms <= pwdata[15:0];
                aldb_pkg::REG_DEBOUNCE_ENABLE: r_cfg.debounce_enable <= pwdata[0];
                aldb_pkg::REG_HOLD_DELAY:      r_cfg.repeat_ms <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            aldb_pkg::REG_BUTTON_IDS:
                prdata = aldb_pkg::DATA_W'(r_cfg.button_ids);
            aldb_pkg::REG_BUTTON_LEVELS:
                prdata = aldb_pkg::DATA_W'(r_cfg.button_levels);
            aldb_pkg::REG_BUTTON_COUNT:
                prdata = aldb_pkg::DATA_W'(r_cfg.button_count);
            aldb_pkg::REG_MATCH_DELTA:
                prdata = aldb_pkg::DATA_W'(r_cfg.match_delta);
            aldb_pkg::REG_TICK_INTERVAL:
                prdata = aldb_pkg::DATA_W'(r_cfg.tick_interval_ms);
            aldb_pkg::REG_DEBOUNCE_DELAY:
                prdata = aldb_pkg::DATA_W'(r_cfg.settle_ms);
            aldb_pkg::REG_DEBOUNCE_ENABLE:
                prdata = aldb_pkg::DATA_W'(r_cfg.debounce_enable);
            aldb_pkg::REG_HOLD_DELAY:
                prdata = aldb_pkg::DATA_W'(r_cfg.repeat_ms);
            default:
                prdata = '0;
        endcase
    end

endmodule

/* hdl/aldb_ctrl.sv */
// ----------------------------------------------------------------------------
// aldb_ctrl
// Sequencer: accept, tick check, table scan, decision and result hand-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aldb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  aldb_pkg::t_stat i_stat,
    output aldb_pkg::t_cmd  o_cmd
);

    aldb_pkg::t_state r_state;
    aldb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aldb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            aldb_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = aldb_pkg::ST_CHECK;
                end
            end
            aldb_pkg::ST_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_stat.skip || i_stat.empty) begin
                    n_state = aldb_pkg::ST_DECIDE;
                end else begin
                    n_state = aldb_pkg::ST_SCAN;
                end
            end
            aldb_pkg::ST_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.hit || i_stat.last) begin
                    n_state = aldb_pkg::ST_DECIDE;
                end
            end
            aldb_pkg::ST_DECIDE: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = aldb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = aldb_pkg::ST_IDLE;
            end
        endcase
    end

    `AST_IMPL(a_commit_free, i_clk, i_rst_n, o_cmd.commit, i_stat.out_free)
    `AST_NEXT(a_load_check, i_clk, i_rst_n, o_cmd.load, r_state == aldb_pkg::ST_CHECK)
    `AST_NEXT(a_scan_end, i_clk, i_rst_n, o_cmd.step && (i_stat.hit || i_stat.last),
              r_state == aldb_pkg::ST_DECIDE)

endmodule

/* hdl/aldb_dp.sv */
// ----------------------------------------------------------------------------
// aldb_dp
// Datapath: input capture, table scan, key state and the output register.
// ----------------------------------------------------------------------------
module aldb_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aldb_pkg::t_cfg     i_cfg,
    input  aldb_pkg::t_in_item i_in_data,
    input  aldb_pkg::t_cmd     i_cmd,
    output aldb_pkg::t_stat    o_stat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output aldb_pkg::t_out_item o_out_data
);

    localparam int IW = aldb_pkg::ID_W;
    localparam int CW = aldb_pkg::CNT_W;

    logic [31:0]               r_now;
    logic [7:0]                r_adc;
    logic                      r_report;
    logic                      r_skip;
    logic [aldb_pkg::IDX_W-1:0] r_idx;
    logic [IW-1:0]             r_match;

    logic [31:0]   r_last_time, n_last_time;
    logic [IW-1:0] r_cur, n_cur;
    logic [31:0]   r_press_time, n_press_time;
    logic [IW-1:0] r_cand, n_cand;
    logic [31:0]   r_cand_start, n_cand_start;
    logic [IW-1:0] r_held, n_held;
    logic [IW-1:0] r_last_rel, n_last_rel;

    logic                r_out_valid;
    aldb_pkg::t_out_item r_out, n_out;

    logic [CW-1:0] w_used;
    logic [IW-1:0] w_ent_id;
    logic [7:0]    w_ent_lvl;
    logic [8:0]    w_lo_sum;
    logic [8:0]    w_hi_sum;
    logic [31:0]   w_tick_diff;
    logic [31:0]   w_deb_diff;
    logic [31:0]   w_hold_diff;
    logic [IW-1:0] w_idle_id;
    logic          w_go;

    assign w_used = (i_cfg.button_count > CW'(aldb_pkg::USED_SLOTS)) ?
                    CW'(aldb_pkg::USED_SLOTS) : i_cfg.button_count;

    assign w_ent_id  = i_cfg.button_ids[{r_idx, 3'b000} +: IW];
    assign w_ent_lvl = i_cfg.button_levels[{r_idx, 3'b000} +: 8];
    assign w_lo_sum  = {1'b0, r_adc} + {1'b0, i_cfg.match_delta};
    assign w_hi_sum  = {1'b0, w_ent_lvl} + {1'b0, i_cfg.match_delta};

    assign w_tick_diff = r_now - r_last_time;
    assign w_deb_diff  = r_now - r_cand_start;
    assign w_hold_diff = r_now - r_press_time;

    assign o_stat.skip     = w_tick_diff < {16'd0, i_cfg.tick_interval_ms};
    assign o_stat.empty    = w_used == '0;
    assign o_stat.hit      = (w_ent_id != '0) && (w_lo_sum >= {1'b0, w_ent_lvl})
                             && ({1'b0, r_adc} <= w_hi_sum);
    assign o_stat.last     = (CW'(r_idx) + CW'(1)) == w_used;
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign w_idle_id = r_report ? r_cur : '0;

    always_comb begin
        n_last_time  = r_last_time;
        n_cur        = r_cur;
        n_press_time = r_press_time;
        n_cand       = r_cand;
        n_cand_start = r_cand_start;
        n_held       = r_held;
        n_last_rel   = r_last_rel;
        n_out        = '0;
        n_out.pressed_id = w_idle_id;
        w_go         = 1'b0;
        if (!r_skip) begin
            n_last_time = r_now;
            w_go        = 1'b1;
            if (r_match != r_cur) begin
                if (i_cfg.debounce_enable) begin
                    if (r_match == r_cand) begin
                        if (w_deb_diff < {16'd0, i_cfg.settle_ms}) begin
                            w_go = 1'b0;
                        end else begin
                            n_cand       = aldb_pkg::NO_CANDIDATE;
                            n_cand_start = '0;
                        end
                    end else begin
                        n_cand       = r_match;
                        n_cand_start = r_now;
                        w_go         = 1'b0;
                    end
                end
                if (w_go) begin
                    n_held = '0;
                    if (r_cur != '0) begin
                        n_out.release_event = 1'b1;
                        n_last_rel          = r_cur;
                    end
                end
            end else if (i_cfg.debounce_enable && (r_cand != aldb_pkg::NO_CANDIDATE)) begin
                n_cand       = aldb_pkg::NO_CANDIDATE;
                n_cand_start = '0;
            end
            if (w_go) begin
                n_out.pressed_id = r_match;
                if (r_match != '0) begin
                    if (r_cur != r_match) begin
                        n_out.press_event = 1'b1;
                        n_press_time      = r_now;
                    end else if (w_hold_diff >= {16'd0, i_cfg.repeat_ms}) begin
                        n_press_time     = r_now;
                        n_out.hold_event = 1'b1;
                        n_held           = r_match;
                    end else if (!r_report) begin
                        n_out.pressed_id = '0;
                    end
                end
                n_cur = r_match;
            end
        end
        n_out.released_id = n_last_rel;
        n_out.holding_id  = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_now    <= i_in_data.now_ms;
            r_adc    <= i_in_data.adc_sample[9:2];
            r_report <= i_in_data.report_held;
        end
        if (i_cmd.check) begin
            r_skip  <= o_stat.skip;
            r_idx   <= '0;
            r_match <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + aldb_pkg::IDX_W'(1);
            if (o_stat.hit) begin
                r_match <= w_ent_id;
            end
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time  <= '0;
            r_cur        <= '0;
            r_press_time <= '0;
            r_cand       <= aldb_pkg::NO_CANDIDATE;
            r_cand_start <= '0;
            r_held       <= '0;
            r_last_rel   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_last_time  <= n_last_time;
                r_cur        <= n_cur;
                r_press_time <= n_press_time;
                r_cand       <= n_cand;
                r_cand_start <= n_cand_start;
                r_held       <= n_held;
                r_last_rel   <= n_last_rel;
                r_out_valid  <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
